// ===== rtl/core/set_assoc_cache_fifo_unit_assert.svh =====
// Assertion macros for the cache tag unit.
`ifndef SET_ASSOC_CACHE_FIFO_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sac_pkg.sv =====
package sac_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_WORDS = 4;

    localparam int ADDR_W      = 32;
    localparam int STAMP_W     = 32;
    localparam int OFFSET_BITS = $clog2(BLOCK_WORDS + 1) - 1;
    localparam int INDEX_BITS  = $clog2(SETS + 1) - 1;
    localparam int SET_W       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS - INDEX_BITS;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
        logic [ADDR_W-1:0]  addr;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] access_time;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way_used;
        logic              evicted;
        logic [ADDR_W-1:0] evicted_address;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } status_t;

endpackage

// ===== rtl/core/sac_if.sv =====
interface sac_req_if;
    logic          valid;
    logic          ready;
    sac_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sac_rsp_if;
    logic          valid;
    logic          ready;
    sac_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sac_ram.sv =====
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/sac_ctrl.sv =====
module sac_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  sac_pkg::status_t status,
    output sac_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic state_reg;
    logic state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold until the result register can take the answer
                if (!status.out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/sac_datapath.sv =====
module sac_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  sac_pkg::cmd_t    cmd,
    output sac_pkg::status_t status,
    input  sac_pkg::req_t    req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output sac_pkg::rsp_t    rsp_data
);

    localparam int WayW = sac_pkg::WAY_W;

    logic [sac_pkg::ADDR_W-1:0]  addr_reg;
    logic [sac_pkg::STAMP_W-1:0] stamp_reg;
    logic [sac_pkg::SET_W-1:0]   set_reg;
    logic [sac_pkg::WAYS-1:0]    valid_reg [sac_pkg::SETS];
    logic                        rsp_valid_reg;
    sac_pkg::rsp_t               rsp_reg;

    logic [sac_pkg::SET_W-1:0]   set_in;
    logic [sac_pkg::TAG_W-1:0]   tag_cur;
    logic [sac_pkg::ROW_W-1:0]   ram_rdata;
    sac_pkg::row_t               row;
    sac_pkg::row_t               row_new;
    logic [sac_pkg::WAYS-1:0]    set_vld;
    logic                        hit;
    logic [WayW-1:0]             hit_way;
    logic                        free_found;
    logic [WayW-1:0]             free_way;
    logic [WayW-1:0]             old_way;
    logic [WayW-1:0]             victim;
    logic                        fill_we;
    sac_pkg::rsp_t               result;

    assign set_in  = req_data.address[sac_pkg::OFFSET_BITS +: sac_pkg::SET_W];
    assign tag_cur = addr_reg[sac_pkg::ADDR_W-1 -: sac_pkg::TAG_W];
    assign row     = sac_pkg::row_t'(ram_rdata);
    assign set_vld = valid_reg[set_reg];

    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        old_way    = '0;
        for (int w = 0; w < sac_pkg::WAYS; w++)
        begin
            if (!hit && set_vld[w] && row[w].tag == tag_cur)
            begin
                hit     = 1'b1;
                hit_way = WayW'(w);
            end
            if (!free_found && !set_vld[w])
            begin
                free_found = 1'b1;
                free_way   = WayW'(w);
            end
        end
        for (int w = 1; w < sac_pkg::WAYS; w++)
        begin
            if (row[w].stamp < row[old_way].stamp)
            begin
                old_way = WayW'(w);
            end
        end
    end

    assign victim  = free_found ? free_way : old_way;
    assign fill_we = cmd.commit && !hit;

    always_comb
    begin
        row_new             = row;
        row_new[victim].tag   = tag_cur;
        row_new[victim].stamp = stamp_reg;
        row_new[victim].addr  = addr_reg;
    end

    always_comb
    begin
        result.hit             = hit;
        result.way_used        = 2'(hit ? hit_way : victim);
        result.evicted         = !hit && !free_found;
        result.evicted_address = (!hit && !free_found) ? row[old_way].addr : '0;
    end

    sac_ram #(
        .WIDTH (sac_pkg::ROW_W),
        .DEPTH (sac_pkg::SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (set_reg),
        .wdata (sac_pkg::ROW_W'(row_new)),
        .re    (cmd.capture),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg  <= req_data.address;
            stamp_reg <= req_data.access_time;
            set_reg   <= set_in;
        end
        if (cmd.commit)
        begin
            rsp_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < sac_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fill_we)
            begin
                valid_reg[set_reg][victim] <= 1'b1;
            end
            priority if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_stall = rsp_valid_reg && !rsp_ready;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp_data         = rsp_reg;

endmodule

// ===== rtl/core/set_assoc_cache_fifo_unit.sv =====
// The result is registered: the set row is read when a request is accepted and the result
// register loads in the lookup state, unless it still holds an untaken result.
// One request is in flight at a time: a new one is taken only in the idle state, after the
// registered read of the set row and its write-back at commit.
// A stalled result holds the lookup; the next request is taken once the result loads.
// Reset clears all valid bits at once; tag, stamp and address rows need no clearing.
`include "set_assoc_cache_fifo_unit_assert.svh"

module set_assoc_cache_fifo_unit (
    input  logic       clk,
    input  logic       rst_n,
    sac_req_if.sink    req,
    sac_rsp_if.source  rsp
);

    sac_pkg::cmd_t    cmd;
    sac_pkg::status_t status;

    sac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sac_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (req.payload),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.payload)
    );

    `SAC_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request accepted during lookup")
    `SAC_ASSERT_IMPL(a_hit_no_evict, rsp.valid && rsp.payload.hit, !rsp.payload.evicted, "hit reports eviction")
    `SAC_ASSERT_IMPL(a_evaddr_zero, rsp.valid && !rsp.payload.evicted, rsp.payload.evicted_address == '0, "address without eviction")
    `SAC_ASSERT_NEXT(a_commit_loads, cmd.commit, rsp.valid, "result lost after commit")

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 430;
    localparam int HOLD_STRETCH = 400;

    class tag_lookup_tracker;
        bit                          line_valid [sac_pkg::SETS][sac_pkg::WAYS];
        logic [sac_pkg::TAG_W-1:0]   line_tag   [sac_pkg::SETS][sac_pkg::WAYS];
        logic [sac_pkg::STAMP_W-1:0] line_stamp [sac_pkg::SETS][sac_pkg::WAYS];
        logic [sac_pkg::ADDR_W-1:0]  line_addr  [sac_pkg::SETS][sac_pkg::WAYS];
        sac_pkg::rsp_t               expected_lookups[$];
        int                          mismatches;

        function new();
            mismatches = 0;
            foreach (line_valid[s, w])
                line_valid[s][w] = 1'b0;
        endfunction

        // Look up the set, fill on a miss and queue the outcome.
        function void note_request(sac_pkg::req_t r);
            int                        set_idx;
            int                        victim;
            bit                        have_free;
            logic [sac_pkg::TAG_W-1:0] tag;
            sac_pkg::rsp_t             outcome;
            set_idx = int'((r.address >> sac_pkg::OFFSET_BITS) & (sac_pkg::SETS - 1));
            tag     = sac_pkg::TAG_W'(r.address >> (sac_pkg::OFFSET_BITS + sac_pkg::INDEX_BITS));
            outcome = '0;
            for (int w = 0; w < sac_pkg::WAYS; w++)
            begin
                if (!outcome.hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag)
                begin
                    outcome.hit      = 1'b1;
                    outcome.way_used = 2'(w);
                end
            end
            if (!outcome.hit)
            begin
                have_free = 1'b0;
                victim    = 0;
                for (int w = 0; w < sac_pkg::WAYS; w++)
                begin
                    if (!have_free && !line_valid[set_idx][w])
                    begin
                        victim    = w;
                        have_free = 1'b1;
                    end
                end
                if (!have_free)
                begin
                    victim = 0;
                    for (int w = 1; w < sac_pkg::WAYS; w++)
                    begin
                        if (line_stamp[set_idx][w] < line_stamp[set_idx][victim])
                            victim = w;
                    end
                    outcome.evicted         = 1'b1;
                    outcome.evicted_address = line_addr[set_idx][victim];
                end
                line_valid[set_idx][victim] = 1'b1;
                line_tag[set_idx][victim]   = tag;
                line_stamp[set_idx][victim] = r.access_time;
                line_addr[set_idx][victim]  = r.address;
                outcome.way_used            = 2'(victim);
            end
            expected_lookups.push_back(outcome);
        endfunction

        function void check_result(sac_pkg::rsp_t got);
            sac_pkg::rsp_t want;
            if (expected_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0d way=%0d evicted=%0d evicted_address=%h",
                             got.hit, got.way_used, got.evicted, got.evicted_address);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.hit !== want.hit || got.way_used !== want.way_used ||
                got.evicted !== want.evicted || got.evicted_address !== want.evicted_address)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected hit=%0d way=%0d evicted=%0d evicted_address=%h, %s",
                             want.hit, want.way_used, want.evicted, want.evicted_address,
                             $sformatf("got hit=%0d way=%0d evicted=%0d evicted_address=%h",
                                       got.hit, got.way_used, got.evicted,
                                       got.evicted_address));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sac_req_if req_ch();
    sac_rsp_if rsp_ch();

    set_assoc_cache_fifo_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tag_lookup_tracker tracker = new();

    int                          send_idle_pct;
    int                          recv_idle_pct;
    int                          hold_cycles;
    int                          idle_run;
    logic [sac_pkg::STAMP_W-1:0] stamp_clock;
    logic [sac_pkg::TAG_W-1:0]   tag_pool [8];
    int                          hot_sets [4];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [sac_pkg::ADDR_W-1:0] make_address(
        logic [sac_pkg::TAG_W-1:0] tag, int set_idx, int offset);
        return (sac_pkg::ADDR_W'(tag) << (sac_pkg::OFFSET_BITS + sac_pkg::INDEX_BITS)) |
               (sac_pkg::ADDR_W'(set_idx & (sac_pkg::SETS - 1)) << sac_pkg::OFFSET_BITS) |
               sac_pkg::ADDR_W'(offset & (sac_pkg::BLOCK_WORDS - 1));
    endfunction

    // Mostly a few busy sets with a small tag pool, so hits and evictions are frequent.
    function automatic sac_pkg::req_t random_request();
        int            pick;
        sac_pkg::req_t r;
        pick = $urandom_range(99);
        if (pick < 60)
            r.address = make_address(tag_pool[$urandom_range(5)], hot_sets[$urandom_range(3)],
                                     $urandom_range(sac_pkg::BLOCK_WORDS - 1));
        else if (pick < 85)
            r.address = make_address(tag_pool[$urandom_range(7)],
                                     $urandom_range(sac_pkg::SETS - 1),
                                     $urandom_range(sac_pkg::BLOCK_WORDS - 1));
        else
            r.address = $urandom;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            stamp_clock   = stamp_clock + sac_pkg::STAMP_W'($urandom_range(3));
            r.access_time = stamp_clock;
        end
        else if (pick < 90)
            r.access_time = $urandom;
        else if (pick < 95)
            r.access_time = '0;
        else
            r.access_time = '1;
        return r;
    endfunction

    task automatic send_request(sac_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_request(r);
    endtask

    task automatic wait_drained();
        while (tracker.expected_lookups.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                tracker.check_result(rsp_ch.payload);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        idle_run = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_cycles    = 0;
        stamp_clock    = '0;
        foreach (tag_pool[i])
            tag_pool[i] = sac_pkg::TAG_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request('{32'h0000_0000, 32'h0000_0000});
        send_request('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_request('{32'h0000_0003, 32'h0000_0007});
        send_request('{make_address(24'h000001, 5, 0), 32'd100});
        send_request('{make_address(24'h800000, 5, 1), 32'd50});
        send_request('{make_address(24'h555555, 5, 2), 32'd50});
        send_request('{make_address(24'hAAAAAA, 5, 3), 32'd200});
        send_request('{make_address(24'h555555, 5, 0), 32'd999});
        send_request('{make_address(24'h123456, 5, 0), 32'd300});
        send_request('{make_address(24'h0F0F0F, 5, 1), 32'd0});
        send_request('{make_address(24'hF0F0F0, 5, 2), 32'd1});
        send_request('{make_address(24'h800000, 5, 3), 32'd2});
        send_request('{make_address(24'h000001, 5, 3), 32'd3});
        send_request('{make_address(24'hFFFFFE, sac_pkg::SETS - 1, 1), 32'hFFFF_FFFF});
        send_request('{make_address(24'h000000, sac_pkg::SETS - 1, 2), 32'hFFFF_FFFF});
        send_request('{make_address(24'h7FFFFF, sac_pkg::SETS - 1, 0), 32'hFFFF_FFFF});
        send_request('{make_address(24'h00FF00, sac_pkg::SETS - 1, 3), 32'd5});
        send_request('{make_address(24'hFFFFFF, sac_pkg::SETS - 1, 0), 32'hFFFF_FFFF});
        req_ch.valid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 31 : 0;
            foreach (hot_sets[i])
                hot_sets[i] = $urandom_range(sac_pkg::SETS - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 0 && i == 150)
                    hold_cycles = HOLD_STRETCH;
                send_request(random_request());
            end
            req_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_lookups.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sac_pkg.sv
rtl/core/sac_if.sv
rtl/core/sac_ram.sv
rtl/core/sac_ctrl.sv
rtl/core/sac_datapath.sv
rtl/core/set_assoc_cache_fifo_unit.sv
tb/testbench.sv
